@@ rtl/core/slrx_pkg.sv @@
// Package for the sync/length/CRC frame receiver.
// Holds the buffer size, the framing constants, the status codes, the result
// struct and the CRC-16 byte update. No dependencies.
package slrx_pkg;

  localparam int BUFFER_BYTES   = 256;
  localparam int POS_W          = $clog2(BUFFER_BYTES + 1);
  localparam int END_W          = 17;
  localparam int HDR_BYTES      = 3;
  localparam int CRC_BYTES      = 2;
  localparam int RESERVED_BYTES = 7;
  localparam int MAX_LEN        = BUFFER_BYTES - RESERVED_BYTES;

  localparam logic [7:0]  SYNC_FIRST  = 8'hDE;
  localparam logic [7:0]  SYNC_SECOND = 8'hAD;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam logic [7:0] TYPE_WRITE_ACK = 8'd2;
  localparam logic [7:0] TYPE_ACK       = 8'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    status_t     status;
    logic [7:0]  msg_type;
    logic [15:0] payload_len;
    logic        ack_seen;
    logic        ack_request;
    logic        deliver;
  } result_t;

  // CRC-16/MODBUS, reflected, one byte per call
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/slrx_in_reg.sv @@
// Input register for the frame receiver: holds one received byte until the
// parser takes it. Depends on nothing but the clock and reset.
module slrx_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte[7:0]
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  assign s_tready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_byte <= s_tdata;
    end
  end

endmodule

@@ rtl/core/slrx_parser.sv @@
// Frame parser: sync hunt, header capture, CRC accumulate and verdict.
// One byte per step; uses slrx_pkg for constants, result_t and crc16_update.
module slrx_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  output slrx_pkg::result_t res
);
  import slrx_pkg::*;

  logic             in_frame, in_frame_next;
  logic [POS_W-1:0] byte_pos, byte_pos_next;
  logic [END_W-1:0] end_pos, end_pos_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       type_hold, type_hold_next;
  logic [15:0]      length_hold, length_hold_next;
  logic [7:0]       crc_low_hold, crc_low_hold_next;

  logic [END_W-1:0] pos_ext;
  logic [END_W-1:0] pos_plus1;
  logic [END_W-1:0] pos_plus2;
  logic [15:0]      len_eff;
  logic [END_W-1:0] end_eff;

  assign pos_ext   = END_W'(byte_pos);
  assign pos_plus1 = pos_ext + END_W'(1);
  assign pos_plus2 = pos_ext + END_W'(CRC_BYTES);
  assign len_eff   = {length_hold[15:8], in_byte};
  assign end_eff   = (byte_pos == POS_W'(2))
                   ? END_W'(len_eff) + END_W'(HDR_BYTES + CRC_BYTES)
                   : end_pos;

  always_comb begin
    in_frame_next     = in_frame;
    byte_pos_next     = byte_pos;
    end_pos_next      = end_pos;
    running_crc_next  = running_crc;
    type_hold_next    = type_hold;
    length_hold_next  = length_hold;
    crc_low_hold_next = crc_low_hold;
    res_valid         = 1'b0;
    res               = '0;
    res.msg_type      = type_hold;
    res.payload_len   = length_hold;

    if (!in_frame) begin
      // loose sync: bytes other than the expected one leave progress alone
      if (in_byte == SYNC_FIRST && byte_pos == '0) begin
        byte_pos_next = POS_W'(1);
      end else if (in_byte == SYNC_SECOND && byte_pos == POS_W'(1)) begin
        in_frame_next    = 1'b1;
        byte_pos_next    = '0;
        running_crc_next = CRC_INIT;
      end
    end else if (byte_pos >= POS_W'(BUFFER_BYTES)) begin
      res_valid        = 1'b1;
      res.kind         = KIND_VERDICT;
      res.status       = ST_OVERFLOW;
      in_frame_next    = 1'b0;
      byte_pos_next    = '0;
      running_crc_next = CRC_INIT;
    end else begin
      byte_pos_next = byte_pos + POS_W'(1);
      if (byte_pos == '0) begin
        type_hold_next = in_byte;
      end else if (byte_pos == POS_W'(1)) begin
        length_hold_next = {in_byte, 8'h00};
      end else if (byte_pos == POS_W'(2)) begin
        length_hold_next = len_eff;
        end_pos_next     = end_eff;
      end

      if (pos_ext < END_W'(HDR_BYTES) || pos_plus2 < end_eff) begin
        running_crc_next = crc16_update(running_crc, in_byte);
        if (pos_ext >= END_W'(HDR_BYTES)) begin
          res_valid       = 1'b1;
          res.kind        = KIND_PAYLOAD;
          res.data_byte   = in_byte;
          res.msg_type    = '0;
          res.payload_len = '0;
        end
      end else if (pos_plus2 == end_eff) begin
        crc_low_hold_next = in_byte;
      end else if (pos_plus1 == end_eff) begin
        res_valid = 1'b1;
        res.kind  = KIND_VERDICT;
        if (length_hold > 16'(MAX_LEN)) begin
          res.status = ST_TOO_BIG;
        end else if ({in_byte, crc_low_hold} != running_crc) begin
          res.status = ST_CRC_ERR;
        end else if (type_hold == TYPE_ACK) begin
          res.status   = ST_OK;
          res.ack_seen = 1'b1;
        end else begin
          res.status      = ST_OK;
          res.ack_request = (type_hold == TYPE_WRITE_ACK);
          res.deliver     = 1'b1;
        end
        in_frame_next    = 1'b0;
        byte_pos_next    = '0;
        running_crc_next = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      byte_pos     <= '0;
      end_pos      <= '0;
      running_crc  <= CRC_INIT;
      type_hold    <= '0;
      length_hold  <= '0;
      crc_low_hold <= '0;
    end else if (step) begin
      in_frame     <= in_frame_next;
      byte_pos     <= byte_pos_next;
      end_pos      <= end_pos_next;
      running_crc  <= running_crc_next;
      type_hold    <= type_hold_next;
      length_hold  <= length_hold_next;
      crc_low_hold <= crc_low_hold_next;
    end
  end

endmodule

@@ rtl/core/sync_length_crc_frame_receiver.sv @@
// Channel  Dir  Signals                      Content
// s_       in   s_tvalid s_tready s_tdata    one received serial byte
// m_       out  m_tvalid m_tready m_tdata    payload byte or frame verdict
//                m_tuser                      kind: payload or verdict
//
// One byte per cycle sustained while m_tready stays high; each byte waits in
// the input register until the output register is free, and then the
// single-pass parser step registers its result there. Bytes that give no
// result (sync, header, CRC) still take one parser step. Reset returns the
// parser to sync hunting.
// With m_tready low the result holds and the input register keeps one more
// byte; s_tready follows m_tready while both registers are full.
//
// Top level; instantiates slrx_in_reg and slrx_parser, uses slrx_pkg.
module sync_length_crc_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // data_byte[7:0], status[9:8], msg_type[17:10], payload_len[33:18],
  // ack_seen[34], ack_request[35], deliver[36], zero fill[39:37]
  output logic [39:0] m_tdata,
  output logic        m_tuser    // kind
);
  import slrx_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       step;
  logic       res_valid;
  result_t    res;

  assign step = hold_valid && (!m_tvalid || m_tready);

  slrx_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (step),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  slrx_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (hold_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      m_tuser <= res.kind;
      m_tdata <= {3'b000, res.deliver, res.ack_request, res.ack_seen,
                  res.payload_len, res.msg_type, res.status, res.data_byte};
    end
  end

endmodule
